### rtl/ssvu_pkg.sv
// Shared types, codes and constants of the sorted sparse vector update block.
package ssvu_pkg;

	// Default sizes of the entry store.
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_INDEX_BITS = 16;

	// Fixed field widths.
	localparam int VAL_W  = 32;
	localparam int VLEN_W = 17;
	localparam int TOL_W  = 16;
	localparam int CFG_W  = 17;

	localparam logic [VLEN_W-1:0] VLEN_RESET = 17'h10000;

	// Item modes; the reserved code acts as a read.
	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_SET  = 2'd1;
	localparam logic [1:0] MODE_ADD  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_ZERO_ADD = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_VECTOR_LENGTH = 1'b0;
	localparam logic CFG_ZERO_TOL      = 1'b1;

	// Operation broadcast to the row of cells.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_REMOVE,
		OP_INSERT
	} cell_op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SEL,
		S_UPD
	} state_t;

	// Control broadcast from the sequencer to the cell row.
	typedef struct packed {
		logic     cmp_en;
		logic     sel_en;
		cell_op_t op;
	} ssvu_ctrl_t;

	// Lookup result gathered from the cell row.
	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] value;
	} ssvu_find_t;

	// True when the magnitude of v is at or below tol.
	function automatic logic near_zero(input logic signed [VAL_W-1:0] v,
			input logic [TOL_W-1:0] tol);
		logic [VAL_W:0] mag;
		mag = v[VAL_W-1] ? ((VAL_W+1)'(0) - {1'b1, v}) : {1'b0, v};
		return mag <= (VAL_W+1)'(tol);
	endfunction

endpackage

### rtl/ssvu_cell.sv
// One cell of the sorted entry row: holds an index and a value and shifts with its neighbors.
module ssvu_cell import ssvu_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssvu_ctrl_t              ctrl,
	input  logic                    occ,
	input  logic [INDEX_BITS-1:0]   pos,
	input  logic signed [VAL_W-1:0] wval,
	input  logic                    left_lt,
	input  logic [INDEX_BITS-1:0]   left_idx,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic [INDEX_BITS-1:0]   right_idx,
	input  logic signed [VAL_W-1:0] right_val,
	output logic                    lt,
	output logic                    eq,
	output logic [INDEX_BITS-1:0]   idx,
	output logic signed [VAL_W-1:0] val,
	output logic signed [VAL_W-1:0] eq_val
);

	logic [INDEX_BITS-1:0]   idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    lt_q;
	logic                    eq_q;

	// Compare the broadcast position against the held index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			lt_q <= occ && (idx_q < pos);
			eq_q <= occ && (idx_q == pos);
		end
	end

	// Overwrite, shift left on removal, or shift right and insert.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WRITE: begin
				if (eq_q) begin
					val_q <= wval;
				end
			end
			OP_REMOVE: begin
				if (!lt_q) begin
					idx_q <= right_idx;
					val_q <= right_val;
				end
			end
			OP_INSERT: begin
				if (!lt_q) begin
					if (left_lt) begin
						idx_q <= pos;
						val_q <= wval;
					end else begin
						idx_q <= left_idx;
						val_q <= left_val;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign lt     = lt_q;
	assign eq     = eq_q;
	assign idx    = idx_q;
	assign val    = val_q;
	assign eq_val = eq_q ? val_q : '0;

endmodule

### rtl/ssvu_chain.sv
// Row of entry cells with the registered gather of the matching entry's value.
module ssvu_chain import ssvu_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int INDEX_BITS = DEF_INDEX_BITS,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssvu_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]        count,
	input  logic [INDEX_BITS-1:0]   pos,
	input  logic signed [VAL_W-1:0] wval,
	output ssvu_find_t              find
);

	logic                    lt_w   [CAPACITY];
	logic                    eq_w   [CAPACITY];
	logic [INDEX_BITS-1:0]   idx_w  [CAPACITY];
	logic signed [VAL_W-1:0] val_w  [CAPACITY];
	logic signed [VAL_W-1:0] eqv_w  [CAPACITY];
	ssvu_find_t              find_d;
	ssvu_find_t              find_q;

	// Each cell talks to its left and right neighbor only.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                    left_lt;
		logic [INDEX_BITS-1:0]   left_idx;
		logic signed [VAL_W-1:0] left_val;
		logic [INDEX_BITS-1:0]   right_idx;
		logic signed [VAL_W-1:0] right_val;
		logic                    occ;

		assign occ = count > CNT_W'(g);

		if (g == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_idx = idx_w[g];
			assign left_val = val_w[g];
		end else begin : g_mid
			assign left_lt  = lt_w[g-1];
			assign left_idx = idx_w[g-1];
			assign left_val = val_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_idx = idx_w[g];
			assign right_val = val_w[g];
		end else begin : g_inner
			assign right_idx = idx_w[g+1];
			assign right_val = val_w[g+1];
		end

		ssvu_cell #(
			.INDEX_BITS(INDEX_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.occ      (occ),
			.pos      (pos),
			.wval     (wval),
			.left_lt  (left_lt),
			.left_idx (left_idx),
			.left_val (left_val),
			.right_idx(right_idx),
			.right_val(right_val),
			.lt       (lt_w[g]),
			.eq       (eq_w[g]),
			.idx      (idx_w[g]),
			.val      (val_w[g]),
			.eq_val   (eqv_w[g])
		);
	end

	// At most one cell matches, so an OR of the gated values picks it out.
	always_comb begin
		find_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			find_d.found = find_d.found | eq_w[i];
			find_d.value = find_d.value | eqv_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_q <= '0;
		end else if (ctrl.sel_en) begin
			find_q <= find_d;
		end
	end

	assign find = find_q;

endmodule

### rtl/sorted_sparse_vector_update.sv
// Top level of the sorted sparse vector update block: sequencer, decision logic and cell row.
//
// Keeps up to CAPACITY nonzero entries of a sparse Q16.16 vector, sorted by index.
// Input items: raise start with mode, position and operand; the item is taken at a
// clock edge where start is high and busy is low. Mode 0 reads, 1 sets, 2 adds.
// Each item gives one result: done is high for one cycle with status, read_value
// and nonzero_count valid in that cycle. The receiver has no way to hold it off.
// After the item is taken, the sequence is compare in every cell, gather of the matching
// value through the OR tree, then decide and shift the row; done is registered from the
// shift cycle, and busy drops in it so the next item can be taken there.
// Configuration: cfg_valid with cfg_index and cfg_data writes a register
// (0 vector length, 1 zero tolerance); cfg_ready is always high. Write only while
// no item is in flight.
// Reset: arst_n clears the entry count, the sequencer and the result strobe, and
// restores vector length 65536 and tolerance 0. Entry cells are not cleared; only
// cells below the entry count take part in a lookup.
module sorted_sparse_vector_update import ssvu_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int INDEX_BITS = DEF_INDEX_BITS,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [INDEX_BITS-1:0]   position,
	input  logic signed [VAL_W-1:0] operand,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] read_value,
	output logic [CNT_W-1:0]        nonzero_count,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int CMP_W = (INDEX_BITS > VLEN_W) ? INDEX_BITS : VLEN_W;

	state_t                  state_q;
	state_t                  state_d;
	ssvu_ctrl_t              ctrl;
	ssvu_find_t              find;
	logic                    accept;
	logic                    upd;

	logic [VLEN_W-1:0]       vlen_q;
	logic [TOL_W-1:0]        tol_q;
	logic [1:0]              mode_q;
	logic [INDEX_BITS-1:0]   pos_q;
	logic signed [VAL_W-1:0] arg_q;
	logic                    oor_q;
	logic                    near_arg_q;
	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic signed [VAL_W-1:0] rval_q;

	cell_op_t                op_d;
	logic [1:0]              status_d;
	logic signed [VAL_W-1:0] rval_d;
	logic signed [VAL_W-1:0] wval_d;
	logic signed [VAL_W:0]   sum_w;
	logic signed [VAL_W-1:0] sat_w;
	logic                    full_w;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VLEN_RESET;
			tol_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VECTOR_LENGTH: vlen_q <= cfg_data[VLEN_W-1:0];
				CFG_ZERO_TOL:      tol_q  <= cfg_data[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer next state.
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  state_d = accept ? S_CMP : S_IDLE;
			S_CMP:   state_d = S_SEL;
			S_SEL:   state_d = S_UPD;
			S_UPD:   state_d = accept ? S_CMP : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer outputs.
	always_comb begin
		busy        = 1'b0;
		upd         = 1'b0;
		ctrl.cmp_en = 1'b0;
		ctrl.sel_en = 1'b0;
		unique case (state_q)
			S_CMP: begin
				busy        = 1'b1;
				ctrl.cmp_en = 1'b1;
			end
			S_SEL: begin
				busy        = 1'b1;
				ctrl.sel_en = 1'b1;
			end
			S_UPD:   upd = 1'b1;
			default: begin
			end
		endcase
		ctrl.op = upd ? op_d : OP_NONE;
	end

	// Item capture, then range and zero checks in the compare cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			pos_q  <= position;
			arg_q  <= operand;
		end
		if (ctrl.cmp_en) begin
			oor_q      <= CMP_W'(pos_q) >= CMP_W'(vlen_q);
			near_arg_q <= near_zero(arg_q, tol_q);
		end
	end

	// Saturating sum of the stored value and the addend.
	assign sum_w  = {find.value[VAL_W-1], find.value} + {arg_q[VAL_W-1], arg_q};
	assign full_w = count_q == CNT_W'(CAPACITY);

	always_comb begin
		sat_w = sum_w[VAL_W-1:0];
		if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
			sat_w = sum_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// Decide the row operation and the result of the item.
	always_comb begin
		op_d     = OP_NONE;
		status_d = ST_OK;
		wval_d   = arg_q;
		rval_d   = find.found ? find.value : '0;
		if (oor_q) begin
			status_d = ST_RANGE;
			rval_d   = '0;
		end else begin
			case (mode_q)
				MODE_SET: begin
					if (near_arg_q) begin
						rval_d = '0;
						if (find.found) begin
							op_d = OP_REMOVE;
						end
					end else if (find.found) begin
						op_d   = OP_WRITE;
						rval_d = arg_q;
					end else if (full_w) begin
						status_d = ST_FULL;
						rval_d   = '0;
					end else begin
						op_d   = OP_INSERT;
						rval_d = arg_q;
					end
				end
				MODE_ADD: begin
					if (near_arg_q) begin
						status_d = ST_ZERO_ADD;
					end else if (find.found) begin
						if (near_zero(sat_w, tol_q)) begin
							op_d   = OP_REMOVE;
							rval_d = '0;
						end else begin
							op_d   = OP_WRITE;
							wval_d = sat_w;
							rval_d = sat_w;
						end
					end else if (full_w) begin
						status_d = ST_FULL;
						rval_d   = '0;
					end else begin
						op_d   = OP_INSERT;
						rval_d = arg_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Entry count and the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= upd;
			if (upd && op_d == OP_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (upd && op_d == OP_REMOVE) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			status_q <= status_d;
			rval_q   <= rval_d;
		end
	end

	ssvu_chain #(
		.CAPACITY  (CAPACITY),
		.INDEX_BITS(INDEX_BITS)
	) u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.count (count_q),
		.pos   (pos_q),
		.wval  (wval_d),
		.find  (find)
	);

	assign done          = done_q;
	assign status        = status_q;
	assign read_value    = rval_q;
	assign nonzero_count = count_q;

endmodule

### rtl/ssvu_checker.sv
// Port-level checks of the sorted sparse vector update block, bound to its top level.
module ssvu_checker import ssvu_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [1:0]              status,
	input logic signed [VAL_W-1:0] read_value,
	input logic [CNT_W-1:0]        nonzero_count
);

	// Every accepted item gets its result once the compare, gather and update states have passed.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result missing four cycles after an accepted item");

	// Busy covers the compare and gather states, so results never come back to back.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// An out-of-range or store-full result reports an absent value.
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_RANGE || status == ST_FULL) |-> read_value == '0)
		else $error("nonzero value with a range or full status");

	// A store-full result only comes with a full store.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> nonzero_count == CNT_W'(CAPACITY))
		else $error("store full reported below capacity");

endmodule

bind sorted_sparse_vector_update ssvu_checker #(
	.CAPACITY  (CAPACITY)
) u_ssvu_checker (.*);
